>>> src/lrbc_pkg.sv
// Shared types and constants of the labelled region box and centroid block.
package lrbc_pkg;

	localparam int CNT_W   = 21;
	localparam int CFG_W   = 4;
	localparam int PIX_W   = 10;
	localparam int BODY_W  = 8;
	localparam int FRAME_W = 32;
	localparam int SLOT_W  = 4;
	localparam int KIND_W  = 2;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [CFG_W-1:0] MAX_PEOPLE_RST = 4'd6;

	// Input item kinds.
	localparam logic IN_PIXEL = 1'b0;
	localparam logic IN_EOF   = 1'b1;

	// Result record kinds.
	typedef enum logic [KIND_W-1:0] {
		REC_LABEL  = 2'd0,
		REC_REGION = 2'd1,
		REC_EMPTY  = 2'd2
	} rec_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PX,
		ST_EMPTY,
		ST_EF_RD,
		ST_EF_LD,
		ST_EF_DIV,
		ST_EF_OUT
	} state_t;

endpackage

>>> src/lrbc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lrbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> src/lrbc_div.sv
// Restoring divider that yields a quotient of QW bits, one bit per cycle.
module lrbc_div
	import lrbc_pkg::*;
#(
	parameter int QW = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CNT_W+QW-1:0] dividend,
	input  logic [CNT_W-1:0]    divisor,
	output logic                busy,
	output logic [QW-1:0]       quotient
);
	localparam int STEP_W = $clog2(QW + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [QW-1:0]     lo_q;
	logic [QW-1:0]     quo_q;
	logic [CNT_W:0]    shifted;
	logic [CNT_W:0]    diff;
	logic              take;

	// The dividend's upper part is already below the divisor, so QW steps suffice.
	assign shifted = {rem_q, lo_q[QW-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign take    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(QW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[CNT_W+QW-1:QW];
			lo_q  <= dividend[QW-1:0];
			div_q <= (divisor == '0) ? CNT_W'(1) : divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
			lo_q  <= lo_q << 1;
			quo_q <= {quo_q[QW-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

>>> src/labelled_region_box_centroid.sv
// Top level: per-body bounding box, pixel count and centroid over a labelled frame.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+--------------------------------------
//   input   | in        | in_valid / in_stall | kind, pixel_x, pixel_y, body_id, frame
//   output  | out       | out_valid/out_stall | record_kind, slot, box, count, centers
//   config  | in        | cfg_valid/cfg_ready | cfg_data (max_people)
//
// A pixel transaction does the table match and memory read in the accepting
// cycle, then the read-modify-write of the slot statistics, after which the
// next transaction can be taken. The slot memory's registered read port sets
// this split into a read step and a write-back step.
// An end of frame reads each used slot, loads the bit-serial dividers that form the
// two centroids, then emits a region record; with no used slot, one empty record.
// Reset clears the control state, the slot count and max_people (to 6); the slot
// memory is not cleared, since an entry is always written before its read data is used.
// A stalled output holds a record-producing state until the held record leaves.
module labelled_region_box_centroid
	import lrbc_pkg::*;
#(
	parameter int SLOTS      = 8,
	parameter int COORD_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data,
	// Input items.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [PIX_W-1:0]   pixel_x,
	input  logic [PIX_W-1:0]   pixel_y,
	input  logic [BODY_W-1:0]  body_id,
	input  logic [FRAME_W-1:0] frame_number,
	// Result items.
	output logic               out_valid,
	input  logic               out_stall,
	output logic [KIND_W-1:0]  record_kind,
	output logic [SLOT_W-1:0]  slot,
	output logic [PIX_W-1:0]   box_x_min,
	output logic [PIX_W-1:0]   box_x_max,
	output logic [PIX_W-1:0]   box_y_min,
	output logic [PIX_W-1:0]   box_y_max,
	output logic [CNT_W-1:0]   pixel_count,
	output logic [PIX_W-1:0]   center_x,
	output logic [PIX_W-1:0]   center_y,
	output logic [BODY_W-1:0]  region_body_id,
	output logic [FRAME_W-1:0] frame_tag,
	output logic               last
);
	localparam int CW     = COORD_BITS;
	localparam int SUM_W  = CNT_W + CW;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int USED_W = $clog2(SLOTS + 1);
	localparam int REC_W  = 4 * CW + CNT_W + 2 * SUM_W;

	state_t state_q, state_d;

	// Configuration register; writes are always taken.
	logic [CFG_W-1:0] max_people_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_people_q <= MAX_PEOPLE_RST;
		end else if (cfg_valid) begin
			max_people_q <= cfg_data;
		end
	end

	// Slot table: body ids live in flops so every slot is compared at once.
	logic [BODY_W-1:0] body_q [SLOTS];
	logic [USED_W-1:0] used_q;
	logic [USED_W-1:0] limit;
	logic              hit;
	logic [IDX_W-1:0]  hit_idx;

	assign limit = ({1'b0, max_people_q} < 5'(SLOTS)) ? USED_W'(max_people_q)
		: USED_W'(SLOTS);

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int t = SLOTS - 1; t >= 0; t--) begin
			if ((USED_W'(t) < used_q) && (body_q[t] == body_id)) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(t);
			end
		end
	end

	// Pixel context held between the read and the write-back.
	logic [CW-1:0]     px_x_q, px_y_q;
	logic              px_hit_q, px_new_q;
	logic [IDX_W-1:0]  px_idx_q;
	logic [BODY_W-1:0] px_body_q;
	logic [FRAME_W-1:0] frame_q;
	logic [IDX_W-1:0]  ef_idx_q;

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// Slot statistics memory.
	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [REC_W-1:0] ram_wdata, ram_rdata;

	lrbc_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic [CW-1:0]    r_xmin, r_xmax, r_ymin, r_ymax;
	logic [CNT_W-1:0] r_cnt;
	logic [SUM_W-1:0] r_sx, r_sy;
	assign {r_xmin, r_xmax, r_ymin, r_ymax, r_cnt, r_sx, r_sy} = ram_rdata;

	// Updated record for a pixel of a known slot, or the first record of a new one.
	logic [CW-1:0]    u_xmin, u_xmax, u_ymax;
	logic [CNT_W-1:0] u_cnt;
	logic [SUM_W-1:0] u_sx, u_sy;
	logic             grow;

	always_comb begin
		grow   = r_cnt < COUNT_MAX;
		u_xmin = (px_x_q < r_xmin) ? px_x_q : r_xmin;
		u_xmax = (px_x_q > r_xmax) ? px_x_q : r_xmax;
		u_ymax = (px_y_q > r_ymax) ? px_y_q : r_ymax;
		u_cnt  = grow ? r_cnt + 1'b1 : r_cnt;
		u_sx   = grow ? r_sx + SUM_W'(px_x_q) : r_sx;
		u_sy   = grow ? r_sy + SUM_W'(px_y_q) : r_sy;
		if (px_new_q) begin
			ram_wdata = {px_x_q, px_x_q, px_y_q, px_y_q, CNT_W'(1),
				SUM_W'(px_x_q), SUM_W'(px_y_q)};
		end else begin
			ram_wdata = {u_xmin, u_xmax, r_ymin, u_ymax, u_cnt, u_sx, u_sy};
		end
	end

	// Centroid dividers.
	logic          div_start, div_busy, div_busy_y;
	logic [CW-1:0] q_x, q_y;

	lrbc_div #(.QW(CW)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (r_sx),
		.divisor  (r_cnt),
		.busy     (div_busy),
		.quotient (q_x)
	);

	lrbc_div #(.QW(CW)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (r_sy),
		.divisor  (r_cnt),
		.busy     (div_busy_y),
		.quotient (q_y)
	);

	logic out_free, ef_last;
	assign out_free = !out_valid || !out_stall;
	assign ef_last  = (USED_W'(ef_idx_q) + 1'b1) == used_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (kind == IN_PIXEL) begin
						state_d = ST_PX;
					end else if (used_q == '0) begin
						state_d = ST_EMPTY;
					end else begin
						state_d = ST_EF_RD;
					end
				end
			end
			ST_PX, ST_EMPTY: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_EF_RD:  state_d = ST_EF_LD;
			ST_EF_LD:  state_d = ST_EF_DIV;
			ST_EF_DIV: begin
				if (!div_busy) state_d = ST_EF_OUT;
			end
			ST_EF_OUT: begin
				if (out_free) state_d = ef_last ? ST_IDLE : ST_EF_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_stall  = 1'b1;
		ram_re    = 1'b0;
		ram_raddr = hit_idx;
		ram_we    = 1'b0;
		ram_waddr = px_idx_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				ram_re   = in_valid;
			end
			ST_PX: ram_we = out_free && (px_hit_q || px_new_q);
			ST_EF_RD: begin
				ram_re    = 1'b1;
				ram_raddr = ef_idx_q;
			end
			ST_EF_LD: div_start = 1'b1;
			ST_EMPTY, ST_EF_DIV, ST_EF_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			used_q   <= '0;
			ef_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_acc) begin
				ef_idx_q <= '0;
			end
			if (state_q == ST_PX && out_free && px_new_q) begin
				used_q <= used_q + 1'b1;
			end
			if (state_q == ST_EF_OUT && out_free) begin
				ef_idx_q <= ef_idx_q + 1'b1;
				if (ef_last) used_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			px_x_q    <= CW'(pixel_x);
			px_y_q    <= CW'(pixel_y);
			px_body_q <= body_id;
			px_hit_q  <= (body_id != '0) && hit;
			px_new_q  <= (body_id != '0) && !hit && (used_q < limit);
			px_idx_q  <= hit ? hit_idx : used_q[IDX_W-1:0];
			frame_q   <= frame_number;
		end
		if (state_q == ST_PX && out_free && px_new_q) begin
			body_q[px_idx_q] <= px_body_q;
		end
	end

	// Output register.
	logic                out_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [PIX_W-1:0]    xmin_q, xmax_q, ymin_q, ymax_q, cx_q, cy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [BODY_W-1:0]   rbody_q;
	logic [FRAME_W-1:0]  tag_q;
	logic                last_q;
	logic                load;

	assign load = out_free && (state_q == ST_PX || state_q == ST_EMPTY
		|| state_q == ST_EF_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= REC_LABEL;
			slot_q  <= '0;
			xmin_q  <= '0;
			xmax_q  <= '0;
			ymin_q  <= '0;
			ymax_q  <= '0;
			cnt_q   <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			rbody_q <= '0;
			tag_q   <= '0;
			last_q  <= 1'b1;
			case (state_q)
				ST_PX: begin
					if (px_hit_q || px_new_q) begin
						slot_q <= SLOT_W'(px_idx_q) + 1'b1;
					end
				end
				ST_EMPTY: begin
					kind_q <= REC_EMPTY;
					tag_q  <= frame_q;
				end
				default: begin
					kind_q  <= REC_REGION;
					slot_q  <= SLOT_W'(ef_idx_q) + 1'b1;
					xmin_q  <= PIX_W'(r_xmin);
					xmax_q  <= PIX_W'(r_xmax);
					ymin_q  <= PIX_W'(r_ymin);
					ymax_q  <= PIX_W'(r_ymax);
					cnt_q   <= r_cnt;
					cx_q    <= PIX_W'(q_x);
					cy_q    <= PIX_W'(q_y);
					rbody_q <= body_q[ef_idx_q];
					tag_q   <= frame_q;
					last_q  <= ef_last;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign record_kind    = kind_q;
	assign slot           = slot_q;
	assign box_x_min      = xmin_q;
	assign box_x_max      = xmax_q;
	assign box_y_min      = ymin_q;
	assign box_y_max      = ymax_q;
	assign pixel_count    = cnt_q;
	assign center_x       = cx_q;
	assign center_y       = cy_q;
	assign region_body_id = rbody_q;
	assign frame_tag      = tag_q;
	assign last           = last_q;

	// The slot count never passes the table size.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(SLOTS))
		else $error("slot count beyond table size");

	// The two dividers run in lockstep.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy == div_busy_y)
		else $error("centroid dividers out of step");

	// The slot memory is only written during a pixel write-back.
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_PX)
		else $error("slot memory written outside pixel update");

	// A new record appears only after a state that produces one.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_PX || $past(state_q) == ST_EMPTY
		|| $past(state_q) == ST_EF_OUT))
		else $error("result without a producing state");
endmodule
